### design/arpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache package
// Shared sizes, codes, word types and sequencer states of the ARP cache and
// responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int ENTRIES   = 8;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 48;

  localparam logic        ACT_PACKET = 1'b0;
  localparam logic        ACT_LOOKUP = 1'b1;

  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  localparam logic [1:0]  KIND_NONE   = 2'd0;
  localparam logic [1:0]  KIND_REPLY  = 2'd1;
  localparam logic [1:0]  KIND_LOOKUP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'd1;

  localparam logic [31:0] OWN_IP_RESET = 32'h0A00_020F;
  localparam logic [47:0] BCAST_MAC    = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        action;
    logic [15:0] arp_opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] tgt_ip;
    logic [31:0] lookup_ip;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] reply_mac;
    logic [31:0] reply_ip;
    logic [47:0] resolved_mac;
    logic        hit;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_CMP,
    ST_RESP
  } state_e;

endpackage
`default_nettype wire

### design/arpc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache channels
// Valid/ready channels for the input word and the result word.
// ----------------------------------------------------------------------------
interface arpc_in_if;
  import arpc_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arpc_out_if;
  import arpc_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/arp_cache_responder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache and responder
// Stores ARP replies in a small table, answers requests for the own address
// and resolves lookups by a sequential scan through one shared comparator.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | word
//  ---------+-----+------------------+-----------------------------------
//  in_s     | in  | valid/ready      | action, opcode, addresses, lookup_ip
//  out_m    | out | valid/ready      | kind, reply addresses, resolved_mac
//  cfg      | in  | cfg_we_i strobe  | cfg_idx_i, cfg_data_i
//
// A packet word passes the EXEC and RESP states before its result is valid.
// A lookup adds a READ and a CMP state per entry scanned (up to ENTRIES);
// each entry needs a table read and a compare in the single 32-bit
// comparator. One word is in work at a time; a finished result waits in
// the output register, and the sequencer holds its next result while that
// register is still full. Reset empties the table at once. The own MAC
// register is accepted but not kept, as no result carries it.
// ----------------------------------------------------------------------------
module arp_cache_responder
  import arpc_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]      cfg_data_i,
  arpc_in_if.sink              in_s,
  arpc_out_if.source           out_m
);

  state_e              state_q, state_d;
  in_word_t            item_q;
  out_word_t           res_q, res_d;
  out_word_t           out_data_q;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         own_ip_q, own_ip_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    idx_next;
  logic [31:0]         rd_ip_q;
  logic [47:0]         rd_mac_q;
  logic [31:0]         mem_ip  [ENTRIES];
  logic [47:0]         mem_mac [ENTRIES];
  logic                wr_en;
  logic [31:0]         cmp_a, cmp_b;
  logic                cmp_eq;
  logic                accept;
  logic                out_free;

  assign accept   = in_s.valid && in_s.ready;
  assign out_free = !out_valid_q || out_m.ready;
  assign idx_next = CNT_W'(idx_q) + CNT_W'(1);

  assign in_s.ready  = (state_q == ST_IDLE);
  assign out_m.valid = out_valid_q;
  assign out_m.data  = out_data_q;

  // The one comparator serves the own-address check and the table scan.
  assign cmp_a  = (state_q == ST_CMP) ? rd_ip_q : item_q.tgt_ip;
  assign cmp_b  = (state_q == ST_CMP) ? item_q.lookup_ip : own_ip_q;
  assign cmp_eq = (cmp_a == cmp_b);

  always_comb begin
    own_ip_d = own_ip_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_IP:  own_ip_d = cfg_data_i[31:0];
        CFG_OWN_MAC: own_ip_d = own_ip_q;
        default:     own_ip_d = own_ip_q;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (item_q.action == ACT_LOOKUP && count_q != '0) state_d = ST_READ;
        else state_d = ST_RESP;
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if (cmp_eq || idx_next == count_q) state_d = ST_RESP;
        else state_d = ST_READ;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    res_d       = res_q;
    idx_d       = idx_q;
    count_d     = count_q;
    wr_en       = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_m.ready) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
      end
      ST_EXEC: begin
        res_d = '0;
        if (item_q.action == ACT_LOOKUP) begin
          res_d.kind         = KIND_LOOKUP;
          res_d.resolved_mac = BCAST_MAC;
        end else if (item_q.arp_opcode == OP_REPLY) begin
          if (count_q < CNT_W'(ENTRIES)) begin
            wr_en   = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end else if (item_q.arp_opcode == OP_REQUEST && cmp_eq) begin
          res_d.kind      = KIND_REPLY;
          res_d.reply_mac = item_q.sender_mac;
          res_d.reply_ip  = item_q.sender_ip;
        end
      end
      ST_CMP: begin
        if (cmp_eq) begin
          res_d.resolved_mac = rd_mac_q;
          res_d.hit          = 1'b1;
        end
        idx_d = idx_next[IDX_W-1:0];
      end
      ST_RESP: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      own_ip_q    <= OWN_IP_RESET;
      count_q     <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      own_ip_q    <= own_ip_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_s.data;
    res_q <= res_d;
    if (state_q == ST_RESP && out_free) out_data_q <= res_q;
  end

  // Entry table: one write port at the fill count, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_ip[count_q[IDX_W-1:0]]  <= item_q.sender_ip;
      mem_mac[count_q[IDX_W-1:0]] <= item_q.sender_mac;
    end
    rd_ip_q  <= mem_ip[idx_q];
    rd_mac_q <= mem_mac[idx_q];
  end

endmodule
`default_nettype wire

### design/arpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARP cache checker
// Port-level properties of the ARP cache and responder, bound to the top.
// ----------------------------------------------------------------------------
module arpc_checker
  import arpc_pkg::*;
(
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid,
  input wire            in_ready,
  input wire            out_valid,
  input wire            out_ready,
  input wire out_word_t out_data
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Only one word is in work: after an acceptance the input closes.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.kind == KIND_NONE |-> out_data == '0)
    else $error("empty result carries data");

  a_reply_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.kind == KIND_REPLY
      |-> !out_data.hit && out_data.resolved_mac == '0)
    else $error("reply result carries lookup fields");

  a_miss_bcast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.kind == KIND_LOOKUP && !out_data.hit
      |-> out_data.resolved_mac == BCAST_MAC && out_data.reply_ip == '0)
    else $error("lookup miss without broadcast MAC");

endmodule

bind arp_cache_responder arpc_checker u_arpc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_data  (out_m.data)
);
`default_nettype wire

### tb/arp_cache_responder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache and responder testbench
// Walks a short directed table through the empty table, requests for the own
// address, stray opcodes, a fill past the table depth and oldest-first
// duplicate lookups. Random words follow over several own address settings.
// Each result is checked against its typed row or a behavioral copy of the cache.
// ----------------------------------------------------------------------------
module arp_cache_responder_tb;
  import arpc_pkg::*;

  typedef struct {
    in_word_t  stim;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  arpc_in_if  in_ch ();
  arpc_out_if out_ch ();

  arp_cache_responder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (in_ch),
    .out_m      (out_ch)
  );

  // Behavioral copy of the cache and the own address register.
  logic [31:0] cache_ip [ENTRIES];
  logic [47:0] cache_mac[ENTRIES];
  int unsigned cache_fill;
  logic [31:0] own_ip_q;

  out_word_t   pending_answers[$];
  dir_row_t    dir_rows[$];
  int unsigned err_cnt;
  bit          tight_send;

  always #2 clk_i = ~clk_i;

  task automatic flag_error(input string what, input logic [63:0] got,
                            input logic [63:0] want);
    if (err_cnt < 40) begin
      $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
    end
    err_cnt++;
  endtask

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  // Works out the answer to one word and updates the cache copy.
  function automatic out_word_t resolve_arp(input in_word_t w);
    out_word_t r;
    int        i;
    r = '0;
    if (w.action == ACT_PACKET) begin
      if (w.arp_opcode == OP_REPLY) begin
        if (cache_fill < ENTRIES) begin
          cache_ip[cache_fill]  = w.sender_ip;
          cache_mac[cache_fill] = w.sender_mac;
          cache_fill++;
        end
      end else if (w.arp_opcode == OP_REQUEST && w.tgt_ip == own_ip_q) begin
        r.kind      = KIND_REPLY;
        r.reply_mac = w.sender_mac;
        r.reply_ip  = w.sender_ip;
      end
    end else begin
      r.kind         = KIND_LOOKUP;
      r.resolved_mac = BCAST_MAC;
      for (i = 0; i < int'(cache_fill); i++) begin
        if (!r.hit && cache_ip[i] == w.lookup_ip) begin
          r.resolved_mac = cache_mac[i];
          r.hit          = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_row(input logic act, input logic [15:0] op,
                         input logic [31:0] sip, input logic [47:0] smac,
                         input logic [31:0] tip, input logic [31:0] lip,
                         input bit typed, input logic [1:0] kind,
                         input logic [47:0] rmac, input logic [31:0] rip,
                         input logic [47:0] resmac, input logic hit);
    dir_row_t row;
    row.stim  = '{act, op, sip, smac, tip, lip};
    row.typed = typed;
    row.want  = '{kind, rmac, rip, resmac, hit};
    dir_rows.push_back(row);
  endtask

  // The answer is queued before the word goes out, so it is always in place
  // by the time the result word can appear.
  task automatic issue_word(input in_word_t w, input out_word_t want);
    int unsigned g;
    pending_answers.push_back(want);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    g = tight_send ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_answers();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    if (idx == CFG_OWN_IP) begin
      own_ip_q = val[31:0];
    end
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin : answer_check
    out_word_t want;
    out_word_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_answers.size() == 0) begin
        flag_error("unexpected word", 64'(got.kind), 64'd0);
      end else begin
        want = pending_answers.pop_front();
        if (got.kind !== want.kind) flag_error("kind", 64'(got.kind), 64'(want.kind));
        if (got.reply_mac !== want.reply_mac)
          flag_error("reply_mac", 64'(got.reply_mac), 64'(want.reply_mac));
        if (got.reply_ip !== want.reply_ip)
          flag_error("reply_ip", 64'(got.reply_ip), 64'(want.reply_ip));
        if (got.resolved_mac !== want.resolved_mac)
          flag_error("resolved_mac", 64'(got.resolved_mac), 64'(want.resolved_mac));
        if (got.hit !== want.hit) flag_error("hit", 64'(got.hit), 64'(want.hit));
      end
    end
  end

  // Result side back-pressure: mostly short stalls, some long ones, and now
  // and then a long stretch with ready held high.
  initial begin : ready_gen
    int unsigned n;
    int unsigned r;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      n = (r < 10) ? $urandom_range(150, 400) : $urandom_range(1, 6);
      out_ch.ready <= 1'b1;
      repeat (n) @(posedge clk_i);
      r = $urandom_range(0, 99);
      n = (r < 45) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(10, 60);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stim
    in_word_t    w;
    out_word_t   want;
    int unsigned done_cnt;
    int unsigned phase;
    int unsigned r;
    int unsigned q;
    logic [31:0] ip_a;
    logic [31:0] ip_b;

    err_cnt     = 0;
    cache_fill  = 0;
    own_ip_q    = OWN_IP_RESET;
    tight_send  = 1'b0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_reg(CFG_OWN_MAC, rand48());

    ip_a = 32'h0A00_0201;
    ip_b = 32'h0A00_0203;
    //      act         opcode      sender_ip     sender_mac          tgt_ip
    //      lookup_ip   typed  kind  reply_mac  reply_ip  resolved_mac  hit
    add_row(ACT_LOOKUP, 16'h0000, 32'h0, 48'h0, 32'h0,
            ip_a, 1, KIND_LOOKUP, 48'h0, 32'h0, BCAST_MAC, 1'b0);
    add_row(ACT_LOOKUP, 16'hFFFF, '1, '1, '1,
            '1, 1, KIND_LOOKUP, 48'h0, 32'h0, BCAST_MAC, 1'b0);
    add_row(ACT_PACKET, OP_REQUEST, '1, '1, OWN_IP_RESET,
            32'h0, 1, KIND_REPLY, '1, '1, 48'h0, 1'b0);
    add_row(ACT_PACKET, OP_REQUEST, 32'h0, 48'h0, OWN_IP_RESET,
            '1, 1, KIND_REPLY, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_PACKET, OP_REQUEST, 32'h0A00_0202, 48'h5254_0012_3402,
            OWN_IP_RESET ^ 32'h1, OWN_IP_RESET, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_PACKET, 16'h0000, 32'h1, 48'h1, OWN_IP_RESET,
            32'h0, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_PACKET, 16'hFFFF, 32'h1, 48'h1, OWN_IP_RESET,
            32'h0, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_PACKET, 16'h0003, 32'h1, 48'h1, OWN_IP_RESET,
            32'h0, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    // Fill the table; the second entry for ip_a is a duplicate.
    add_row(ACT_PACKET, OP_REPLY, 32'h0, 48'h0123_4567_89AB, 32'h0,
            32'h0, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_PACKET, OP_REPLY, '1, '1, '1,
            '1, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_PACKET, OP_REPLY, ip_a, 48'h5254_0012_3401, OWN_IP_RESET,
            32'h0, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_PACKET, OP_REPLY, 32'h0A00_0202, 48'h5254_0012_3402, 32'h0,
            32'h0, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_PACKET, OP_REPLY, ip_a, 48'h5254_0012_34FF, 32'h0,
            32'h0, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_PACKET, OP_REPLY, 32'hC0A8_0001, 48'h0000_0000_0001, 32'h0,
            32'h0, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_PACKET, OP_REPLY, OWN_IP_RESET, 48'h8000_0000_0000, 32'h0,
            32'h0, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_PACKET, OP_REPLY, 32'h7F00_0001, 48'h0A0B_0C0D_0E0F, 32'h0,
            32'h0, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    // The table is full now, so this entry is dropped.
    add_row(ACT_PACKET, OP_REPLY, ip_b, 48'hDEAD_BEEF_0001, 32'h0,
            ip_b, 1, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0,
            ip_a, 0, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0,
            ip_b, 1, KIND_LOOKUP, 48'h0, 32'h0, BCAST_MAC, 1'b0);
    add_row(ACT_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0,
            32'h0, 0, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0,
            '1, 0, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_LOOKUP, OP_REQUEST, '1, '1, OWN_IP_RESET,
            32'h7F00_0001, 0, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);
    add_row(ACT_PACKET, OP_REQUEST, 32'h0A00_0202, 48'h5254_0012_3402, OWN_IP_RESET,
            32'h7F00_0001, 0, KIND_NONE, 48'h0, 32'h0, 48'h0, 1'b0);

    foreach (dir_rows[i]) begin
      want = resolve_arp(dir_rows[i].stim);
      issue_word(dir_rows[i].stim, dir_rows[i].typed ? dir_rows[i].want : want);
    end

    for (phase = 0; phase < 6; phase++) begin
      wait_for_answers();
      case (phase)
        0: begin
          set_reg(CFG_OWN_IP, CFG_W'({rand48() >> 32, 32'h0}));
          set_reg(CFG_OWN_MAC, '1);
        end
        1: begin
          set_reg(CFG_OWN_IP, {16'h0, 32'hFFFF_FFFF});
          set_reg(CFG_OWN_MAC, '0);
        end
        default: begin
          set_reg(CFG_OWN_IP, rand48());
          set_reg(CFG_OWN_MAC, rand48());
        end
      endcase
      tight_send = (phase == 2);
      done_cnt   = 0;
      while (done_cnt < 155) begin
        w.action     = ACT_PACKET;
        w.arp_opcode = 16'($urandom);
        w.sender_ip  = $urandom;
        w.sender_mac = rand48();
        w.tgt_ip     = $urandom;
        w.lookup_ip  = $urandom;
        r = $urandom_range(0, 99);
        if (r < 45) begin
          w.action = ACT_LOOKUP;
          q = $urandom_range(0, 9);
          if (q < 5 && cache_fill > 0) begin
            w.lookup_ip = cache_ip[$urandom_range(0, cache_fill - 1)];
          end else if (q < 6) begin
            w.lookup_ip = own_ip_q;
          end else if (q < 8 && cache_fill > 0) begin
            w.lookup_ip = cache_ip[$urandom_range(0, cache_fill - 1)]
                          ^ (32'h1 << $urandom_range(0, 31));
          end
        end else if (r < 70) begin
          w.arp_opcode = OP_REQUEST;
          w.tgt_ip     = own_ip_q;
        end else if (r < 80) begin
          w.arp_opcode = OP_REQUEST;
          if ($urandom_range(0, 1)) w.tgt_ip = own_ip_q ^ (32'h1 << $urandom_range(0, 31));
        end else if (r < 92) begin
          w.arp_opcode = OP_REPLY;
        end else if (r < 96) begin
          w.arp_opcode = $urandom_range(0, 1) ? 16'h0100 : 16'h0200;
        end
        want = resolve_arp(w);
        done_cnt++;
        issue_word(w, want);
        if ($urandom_range(0, 149) == 0) wait_for_answers();
      end
    end

    wait_for_answers();
    repeat (25) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
